// ===== rtl/core/majority_smoother_switch_tracker_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the majority smoother switch tracker
// Immediate-implication and next-cycle-implication property checks.
// ---------------------------------------------------------------------------
`ifndef MAJORITY_SMOOTHER_SWITCH_TRACKER_MACROS_SVH
`define MAJORITY_SMOOTHER_SWITCH_TRACKER_MACROS_SVH

// check cons in the same cycle as ante
`define MSST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define MSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/msst_pkg.sv =====
// ---------------------------------------------------------------------------
// msst_pkg
// Widths, class codes and limits shared by the smoother and its divider.
// ---------------------------------------------------------------------------
`default_nettype none

package msst_pkg;

   localparam int HALF_WINDOW_DEF = 6;

   localparam int CLASS_W = 2;
   localparam int TIME_W  = 16;
   localparam int RATE_W  = 16;
   localparam int COUNT_W = 16;
   localparam int MEAN_W  = 24;
   localparam int FRAC_W  = 8;

   // interval, scaled difference and widened sum
   localparam int IV_W   = TIME_W + 1;
   localparam int DIFF_W = IV_W + FRAC_W + 1;
   localparam int SUM_W  = DIFF_W + 1;

   localparam logic [CLASS_W-1:0] CLASS_0   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_1   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_2   = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_MAX = CLASS_2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic signed [MEAN_W-1:0] MEAN_MAX = 24'sh7FFFFF;
   localparam logic signed [MEAN_W-1:0] MEAN_MIN = 24'sh800000;

endpackage

`default_nettype wire

// ===== rtl/core/msst_div.sv =====
// ---------------------------------------------------------------------------
// msst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module msst_div #(
   parameter int NUM_W = msst_pkg::DIFF_W,
   parameter int DEN_W = msst_pkg::COUNT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_sh;
   logic              fits;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
      fits     = rem_sh >= {1'b0, den_ff};
      steps_in = steps_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         steps_in = STEP_W'(NUM_W);
         quo_in   = num;
         rem_in   = '0;
         den_in   = den;
      end else if (steps_ff != '0) begin
         // shift in the next dividend bit and subtract where it fits
         rem_in   = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         steps_in = steps_ff - STEP_W'(1);
         done_in  = steps_ff == STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/majority_smoother_switch_tracker.sv =====
// ---------------------------------------------------------------------------
// majority_smoother_switch_tracker
// Sliding-window majority filter over class labels with switch tracking.
//
// The req channel carries one item per period: raw class, time and rate.
// The rsp channel returns one item per request: smoothed class, switch flag
// and the switch time, rate, interval count and running mean interval.
// req_stall is high while an item is in work; one item is handled at a time.
// The vote tallies one window entry per cycle, over the fill labels in the
// window (1 up to 2*HALF_WINDOW+1). A switch that updates the mean also
// runs the serial divider (one quotient bit per cycle).
// The next item is taken on the cycle after the result enters the output
// register, even while rsp_stall holds that result.
// When rsp_stall is high the result holds; a finished item waits in its
// last step until the output register is free.
// Synchronous reset empties the window and clears all switch history.
// ---------------------------------------------------------------------------
`default_nettype none

`include "majority_smoother_switch_tracker_macros.svh"

module majority_smoother_switch_tracker #(
   parameter int HALF_WINDOW = msst_pkg::HALF_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [msst_pkg::CLASS_W-1:0] req_raw_class,
   input  logic signed [msst_pkg::TIME_W-1:0]  req_period_time,
   input  logic        [msst_pkg::RATE_W-1:0]  req_rate_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [msst_pkg::CLASS_W-1:0] rsp_smoothed_class,
   output logic                                rsp_switched,
   output logic                                rsp_switch_seen,
   output logic signed [msst_pkg::TIME_W-1:0]  rsp_last_switch_time,
   output logic        [msst_pkg::RATE_W-1:0]  rsp_rate_at_switch,
   output logic        [msst_pkg::COUNT_W-1:0] rsp_interval_count,
   output logic signed [msst_pkg::MEAN_W-1:0]  rsp_avg_interval
);
   import msst_pkg::*;

   localparam int WINDOW_LEN = 2 * HALF_WINDOW + 1;
   localparam int IDX_W      = $clog2(WINDOW_LEN);
   localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_LEN - 1);
   localparam logic [FILL_W-1:0] FULL     = FILL_W'(WINDOW_LEN);

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_VOTE, ST_DIV, ST_DONE} state_type;

   state_type state_ff, state_in;

   logic [CLASS_W-1:0] window_ff [WINDOW_LEN];
   logic               win_we;
   logic [CLASS_W-1:0] win_wdata;

   logic [IDX_W-1:0]         wpos_ff, wpos_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [FILL_W-1:0]        tally0_ff, tally0_in;
   logic [FILL_W-1:0]        tally1_ff, tally1_in;
   logic [FILL_W-1:0]        tally2_ff, tally2_in;
   logic signed [TIME_W-1:0] cur_time_ff, cur_time_in;
   logic [RATE_W-1:0]        cur_rate_ff, cur_rate_in;
   logic [CLASS_W-1:0]       prev_class_ff, prev_class_in;
   logic                     prev_valid_ff, prev_valid_in;
   logic signed [TIME_W-1:0] switch_time_ff, switch_time_in;
   logic                     switch_valid_ff, switch_valid_in;
   logic [RATE_W-1:0]        switch_rate_ff, switch_rate_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic                     switched_ff, switched_in;
   logic                     diff_neg_ff, diff_neg_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]       rsp_class_ff, rsp_class_in;
   logic                     rsp_switched_ff, rsp_switched_in;
   logic                     rsp_seen_ff, rsp_seen_in;
   logic signed [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic [RATE_W-1:0]        rsp_rate_ff, rsp_rate_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;

   logic [CLASS_W-1:0]       vote;
   logic [CLASS_W-1:0]       raw_clamped;
   logic [COUNT_W-1:0]       count_next;
   logic signed [IV_W-1:0]   interval;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_mag;
   logic signed [SUM_W-1:0]  q_mag;
   logic signed [SUM_W-1:0]  q_signed;
   logic signed [SUM_W-1:0]  mean_sum;
   logic                     div_start;
   logic                     div_done;
   logic [DIFF_W-1:0]        div_quot;

   msst_div #(
      .NUM_W(DIFF_W),
      .DEN_W(COUNT_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (diff_mag),
      .den  (count_next),
      .done (div_done),
      .quot (div_quot)
   );

   // majority with ties to the lowest class
   always_comb begin
      vote = CLASS_0;
      if (tally1_ff > tally0_ff) begin
         vote = CLASS_1;
      end
      if (tally2_ff > ((vote == CLASS_1) ? tally1_ff : tally0_ff)) begin
         vote = CLASS_2;
      end
   end

   always_comb begin
      raw_clamped = (req_raw_class > CLASS_MAX) ? CLASS_MAX : req_raw_class;
      count_next  = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
      interval    = IV_W'(cur_time_ff) - IV_W'(switch_time_ff);
      diff        = (DIFF_W'(interval) <<< FRAC_W) - DIFF_W'(mean_ff);
      diff_mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      q_mag       = $signed({1'b0, div_quot});
      q_signed    = diff_neg_ff ? -q_mag : q_mag;
      mean_sum    = SUM_W'(mean_ff) + q_signed;
   end

   always_comb begin
      state_in        = state_ff;
      win_we          = 1'b0;
      win_wdata       = raw_clamped;
      wpos_in         = wpos_ff;
      fill_in         = fill_ff;
      idx_in          = idx_ff;
      tally0_in       = tally0_ff;
      tally1_in       = tally1_ff;
      tally2_in       = tally2_ff;
      cur_time_in     = cur_time_ff;
      cur_rate_in     = cur_rate_ff;
      prev_class_in   = prev_class_ff;
      prev_valid_in   = prev_valid_ff;
      switch_time_in  = switch_time_ff;
      switch_valid_in = switch_valid_ff;
      switch_rate_in  = switch_rate_ff;
      count_in        = count_ff;
      mean_in         = mean_ff;
      switched_in     = switched_ff;
      diff_neg_in     = diff_neg_ff;
      div_start       = 1'b0;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_class_in    = rsp_class_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_seen_in     = rsp_seen_ff;
      rsp_time_in     = rsp_time_ff;
      rsp_rate_in     = rsp_rate_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_mean_in     = rsp_mean_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               win_we      = 1'b1;
               wpos_in     = (wpos_ff == LAST_IDX) ? '0 : wpos_ff + IDX_W'(1);
               fill_in     = (fill_ff == FULL) ? fill_ff : fill_ff + FILL_W'(1);
               idx_in      = '0;
               tally0_in   = '0;
               tally1_in   = '0;
               tally2_in   = '0;
               cur_time_in = req_period_time;
               cur_rate_in = req_rate_value;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (window_ff[idx_ff])
               CLASS_0: tally0_in = tally0_ff + FILL_W'(1);
               CLASS_1: tally1_in = tally1_ff + FILL_W'(1);
               default: tally2_in = tally2_ff + FILL_W'(1);
            endcase
            if (FILL_W'(idx_ff) == fill_ff - FILL_W'(1)) begin
               state_in = ST_VOTE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_VOTE: begin
            switched_in   = prev_valid_ff && (vote != prev_class_ff);
            prev_class_in = vote;
            prev_valid_in = 1'b1;
            state_in      = ST_DONE;
            if (switched_in) begin
               switch_time_in  = cur_time_ff;
               switch_rate_in  = cur_rate_ff;
               switch_valid_in = 1'b1;
               if (switch_valid_ff) begin
                  // mean += (interval - mean) / count, after the count steps
                  count_in    = count_next;
                  diff_neg_in = diff[DIFF_W-1];
                  div_start   = 1'b1;
                  state_in    = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (mean_sum > SUM_W'(MEAN_MAX)) begin
                  mean_in = MEAN_MAX;
               end else if (mean_sum < SUM_W'(MEAN_MIN)) begin
                  mean_in = MEAN_MIN;
               end else begin
                  mean_in = MEAN_W'(mean_sum);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_class_in    = prev_class_ff;
               rsp_switched_in = switched_ff;
               rsp_seen_in     = switch_valid_ff;
               rsp_time_in     = switch_time_ff;
               rsp_rate_in     = switch_rate_ff;
               rsp_count_in    = count_ff;
               rsp_mean_in     = mean_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wpos_ff         <= '0;
         fill_ff         <= '0;
         prev_class_ff   <= CLASS_0;
         prev_valid_ff   <= 1'b0;
         switch_time_ff  <= '0;
         switch_valid_ff <= 1'b0;
         switch_rate_ff  <= '0;
         count_ff        <= '0;
         mean_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         wpos_ff         <= wpos_in;
         fill_ff         <= fill_in;
         prev_class_ff   <= prev_class_in;
         prev_valid_ff   <= prev_valid_in;
         switch_time_ff  <= switch_time_in;
         switch_valid_ff <= switch_valid_in;
         switch_rate_ff  <= switch_rate_in;
         count_ff        <= count_in;
         mean_ff         <= mean_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff          <= idx_in;
      tally0_ff       <= tally0_in;
      tally1_ff       <= tally1_in;
      tally2_ff       <= tally2_in;
      cur_time_ff     <= cur_time_in;
      cur_rate_ff     <= cur_rate_in;
      switched_ff     <= switched_in;
      diff_neg_ff     <= diff_neg_in;
      rsp_class_ff    <= rsp_class_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_seen_ff     <= rsp_seen_in;
      rsp_time_ff     <= rsp_time_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_mean_ff     <= rsp_mean_in;
   end

   // window entries beyond the fill count are never read
   always_ff @(posedge clock) begin
      if (win_we) begin
         window_ff[wpos_ff] <= win_wdata;
      end
   end

   assign req_stall            = state_ff != ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_smoothed_class   = rsp_class_ff;
   assign rsp_switched         = rsp_switched_ff;
   assign rsp_switch_seen      = rsp_seen_ff;
   assign rsp_last_switch_time = rsp_time_ff;
   assign rsp_rate_at_switch   = rsp_rate_ff;
   assign rsp_interval_count   = rsp_count_ff;
   assign rsp_avg_interval     = rsp_mean_ff;

   `MSST_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_DONE), "result loaded outside done step")
   `MSST_ASSERT_NOW(a_div_in_div, clock, reset, div_done, state_ff == ST_DIV,
      "divider finished outside divide step")
   `MSST_ASSERT_NEXT(a_div_to_done, clock, reset, (state_ff == ST_DIV) && div_done,
      state_ff == ST_DONE, "mean update did not finish")
   `MSST_ASSERT_NOW(a_count_needs_switch, clock, reset, count_ff != '0, switch_valid_ff,
      "interval counted without a switch")
   `MSST_ASSERT_NOW(a_switch_seen, clock, reset, rsp_valid_ff && rsp_switched_ff,
      rsp_seen_ff, "switch reported without switch history")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the majority smoother switch tracker. Items go in on the
// req channel while an in-bench predictor tracks the vote window, the switch
// history and the running mean interval; every rsp item is checked field by
// field against the oldest prediction. Both channels idle at random, but for the final steady test.
// ---------------------------------------------------------------------------

module tb_top;
   import msst_pkg::*;

   localparam int WIN_LEN = 2 * HALF_WINDOW_DEF + 1;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [CLASS_W-1:0] CLASS_BAD = 2'd3;

   typedef struct {
      logic [CLASS_W-1:0]       smoothed;
      logic                     switched;
      logic                     seen;
      logic signed [TIME_W-1:0] sw_time;
      logic [RATE_W-1:0]        sw_rate;
      logic [COUNT_W-1:0]       iv_total;
      logic signed [MEAN_W-1:0] mean;
   } smooth_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CLASS_W-1:0] req_raw_class;
   logic signed [TIME_W-1:0] req_period_time;
   logic [RATE_W-1:0] req_rate_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [CLASS_W-1:0] rsp_smoothed_class;
   logic rsp_switched;
   logic rsp_switch_seen;
   logic signed [TIME_W-1:0] rsp_last_switch_time;
   logic [RATE_W-1:0] rsp_rate_at_switch;
   logic [COUNT_W-1:0] rsp_interval_count;
   logic signed [MEAN_W-1:0] rsp_avg_interval;

   // predictor state
   logic [CLASS_W-1:0] vote_win [WIN_LEN];
   int win_fill;
   int win_ptr;
   logic [CLASS_W-1:0] last_class;
   bit last_ok;
   logic signed [TIME_W-1:0] sw_time_q;
   bit sw_ok;
   logic [RATE_W-1:0] sw_rate_q;
   logic [COUNT_W-1:0] iv_count_q;
   logic signed [MEAN_W-1:0] iv_mean_q;

   smooth_result_type pending_results[$];

   int err_cnt = 0;
   int n_items = 0;
   int n_results = 0;
   int n_switches = 0;
   int n_mean_updates = 0;
   int n_clamps = 0;
   int quiet_cycles = 0;
   int hold_request = 0;
   int hold_left = 0;
   int burst_left = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   logic signed [TIME_W-1:0] now_months = '0;

   majority_smoother_switch_tracker i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_raw_class        (req_raw_class),
      .req_period_time      (req_period_time),
      .req_rate_value       (req_rate_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_smoothed_class   (rsp_smoothed_class),
      .rsp_switched         (rsp_switched),
      .rsp_switch_seen      (rsp_switch_seen),
      .rsp_last_switch_time (rsp_last_switch_time),
      .rsp_rate_at_switch   (rsp_rate_at_switch),
      .rsp_interval_count   (rsp_interval_count),
      .rsp_avg_interval     (rsp_avg_interval)
   );

   always #5 clock = ~clock;

   // push one label into the window, vote, and update the switch history
   function automatic smooth_result_type predict_smooth(input logic [CLASS_W-1:0] raw,
                                                        input logic signed [TIME_W-1:0] t,
                                                        input logic [RATE_W-1:0] rate);
      int tally [3];
      logic [CLASS_W-1:0] lbl;
      logic [CLASS_W-1:0] best;
      longint ivl;
      longint diff;
      longint nm;
      smooth_result_type r;
      lbl = (raw > CLASS_MAX) ? CLASS_MAX : raw;
      vote_win[win_ptr] = lbl;
      win_ptr = (win_ptr + 1) % WIN_LEN;
      if (win_fill < WIN_LEN) begin
         win_fill++;
      end
      tally = '{0, 0, 0};
      for (int i = 0; i < win_fill; i++) begin
         tally[vote_win[i]]++;
      end
      best = CLASS_0;
      if (tally[CLASS_1] > tally[best]) begin
         best = CLASS_1;
      end
      if (tally[CLASS_2] > tally[best]) begin
         best = CLASS_2;
      end
      r.switched = 1'b0;
      if (last_ok && best != last_class) begin
         r.switched = 1'b1;
         n_switches++;
         if (sw_ok) begin
            ivl = longint'(t) - longint'(sw_time_q);
            if (iv_count_q != COUNT_MAX) begin
               iv_count_q++;
            end
            diff = ivl * 256 - longint'(iv_mean_q);
            nm = longint'(iv_mean_q) + diff / longint'(iv_count_q);
            if (nm > longint'(MEAN_MAX)) begin
               nm = longint'(MEAN_MAX);
               n_clamps++;
            end
            if (nm < longint'(MEAN_MIN)) begin
               nm = longint'(MEAN_MIN);
               n_clamps++;
            end
            iv_mean_q = nm[MEAN_W-1:0];
            n_mean_updates++;
         end
         sw_time_q = t;
         sw_rate_q = rate;
         sw_ok = 1'b1;
      end
      last_class = best;
      last_ok = 1'b1;
      r.smoothed = best;
      r.seen = sw_ok;
      r.sw_time = sw_time_q;
      r.sw_rate = sw_rate_q;
      r.iv_total = iv_count_q;
      r.mean = iv_mean_q;
      return r;
   endfunction

   // offer one item, hold it until taken, then predict its result
   task automatic send_item(input logic [CLASS_W-1:0] raw,
                            input logic signed [TIME_W-1:0] t,
                            input logic [RATE_W-1:0] rate);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_class <= raw;
      req_period_time <= t;
      req_rate_value <= rate;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_results.insert(pending_results.size(), predict_smooth(raw, t, rate));
      n_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic report_field(input string name, input logic [MEAN_W-1:0] exp_v,
                               input logic [MEAN_W-1:0] act_v);
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
   endtask

   // advance time by a small step, now and then jump anywhere
   task automatic step_time();
      if ($urandom_range(0, 19) == 0) begin
         now_months = TIME_W'($urandom);
      end else begin
         now_months = TIME_W'(now_months + $urandom_range(1, 4));
      end
   endtask

   task automatic test_directed();
      // class code three first, then a first switch at the lowest time
      send_item(CLASS_BAD, 16'sh8000, 16'hFFFF);
      send_item(CLASS_0, 16'sh8000, 16'hFFFF);
      send_item(CLASS_1, 16'sh7FFF, 16'h0000);
      // second switch at the highest time: interval overflows the mean
      send_item(CLASS_1, 16'sh7FFF, 16'h0000);
      send_item(CLASS_2, 16'sh0000, 16'h0001);
      // switch back to an earlier time: negative interval
      send_item(CLASS_2, 16'sh0000, 16'h8000);
      // fill and wrap the window
      for (int k = 0; k < WIN_LEN + 1; k++) begin
         send_item(CLASS_W'(k), 16'sh0064 + 16'(k * 5), 16'($urandom));
      end
   endtask

   task automatic test_random_noise();
      for (int k = 0; k < 300; k++) begin
         send_item(CLASS_W'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end
   endtask

   // runs of one class with mostly rising time, a few stray labels
   task automatic test_class_runs();
      logic [CLASS_W-1:0] run_class;
      int run_len;
      int sent;
      sent = 0;
      now_months = TIME_W'($urandom);
      while (sent < 1100) begin
         run_class = CLASS_W'($urandom_range(0, 3));
         run_len = $urandom_range(1, 16);
         for (int k = 0; k < run_len; k++) begin
            step_time();
            if ($urandom_range(0, 9) == 0) begin
               send_item(CLASS_W'($urandom_range(0, 3)), now_months, 16'($urandom));
            end else begin
               send_item(run_class, now_months, 16'($urandom));
            end
            sent++;
         end
      end
   endtask

   // hold off the rsp side so the block fills up and stalls its input
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      for (int k = 0; k < 25; k++) begin
         step_time();
         send_item(CLASS_W'($urandom_range(0, 3)), now_months, 16'($urandom));
      end
   endtask

   task automatic test_drain_pause();
      for (int k = 0; k < 40; k++) begin
         step_time();
         send_item(CLASS_W'($urandom_range(0, 3)), now_months, 16'($urandom));
         if (k % 10 == 9) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
   endtask

   // alternating labels flip the majority on every item once the window holds only the two labels
   task automatic test_alternating();
      logic [CLASS_W-1:0] lo;
      logic [CLASS_W-1:0] hi;
      lo = CLASS_0;
      hi = CLASS_1;
      for (int k = 0; k < 150; k++) begin
         if (k % 50 == 0) begin
            lo = CLASS_W'($urandom_range(0, 1));
            hi = CLASS_W'($urandom_range(lo + 1, 3));
         end
         step_time();
         send_item((k % 2 == 0) ? lo : hi, now_months, 16'($urandom));
      end
   endtask

   task automatic test_final_steady();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int k = 0; k < 200; k++) begin
         step_time();
         send_item(CLASS_W'($urandom_range(0, 3)), now_months, 16'($urandom));
      end
   endtask

   // rsp side: random stall bursts plus one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst_left != 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(0, 7);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      smooth_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_results.size() == 0) begin
            err_cnt++;
            $display("%0t: result with nothing expected, class %0d", $time,
                     rsp_smoothed_class);
         end else begin
            e = pending_results.pop_front();
            if (rsp_smoothed_class !== e.smoothed)
               report_field("smoothed_class", MEAN_W'(e.smoothed),
                            MEAN_W'(rsp_smoothed_class));
            if (rsp_switched !== e.switched)
               report_field("switched", MEAN_W'(e.switched), MEAN_W'(rsp_switched));
            if (rsp_switch_seen !== e.seen)
               report_field("switch_seen", MEAN_W'(e.seen), MEAN_W'(rsp_switch_seen));
            if (rsp_last_switch_time !== e.sw_time)
               report_field("last_switch_time", MEAN_W'(e.sw_time),
                            MEAN_W'(rsp_last_switch_time));
            if (rsp_rate_at_switch !== e.sw_rate)
               report_field("rate_at_switch", MEAN_W'(e.sw_rate),
                            MEAN_W'(rsp_rate_at_switch));
            if (rsp_interval_count !== e.iv_total)
               report_field("interval_count", MEAN_W'(e.iv_total),
                            MEAN_W'(rsp_interval_count));
            if (rsp_avg_interval !== e.mean)
               report_field("avg_interval", e.mean, rsp_avg_interval);
         end
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  QUIET_LIMIT, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_class = '0;
      req_period_time = '0;
      req_rate_value = '0;
      foreach (vote_win[i]) vote_win[i] = CLASS_0;
      win_fill = 0;
      win_ptr = 0;
      last_class = CLASS_0;
      last_ok = 1'b0;
      sw_time_q = '0;
      sw_ok = 1'b0;
      sw_rate_q = '0;
      iv_count_q = '0;
      iv_mean_q = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_noise();
      test_class_runs();
      test_backpressure();
      test_drain_pause();
      test_alternating();
      test_final_steady();
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d items, checked %0d results: %0d class switches, %0d mean updates",
               n_items, n_results, n_switches, n_mean_updates);
      $display("Window fill and wrap, class code 3, time extremes, %0d mean clamps, stalls",
               n_clamps);
      if (err_cnt == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
